/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the step/dir pulse generator RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SDPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdpg assertion failed");

// Next-cycle implication, disabled while in reset
`define SDPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdpg assertion failed");

`endif

/* hw/rtl/sdpg_pkg.sv */
// Package for the step/dir pulse train generator: sizes, op and register codes,
// and the structs between the sequencer, the command queue and the divider.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdpg_pkg;

    // Command queue (ring, holds QUEUE_DEPTH-1 entries)
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Datapath
    localparam int DATA_W    = 32;
    localparam int DIV_CNT_W = $clog2(DATA_W);
    localparam int COUNT_W   = 6;

    // Op codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_CMD   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    // Configuration register indexes
    localparam int         CFG_IDX_W   = 2;
    localparam logic [1:0] CFG_PERIOD  = 2'd0;
    localparam logic [1:0] CFG_DIR_POL = 2'd1;
    localparam logic [1:0] CFG_EN_POL  = 2'd2;

    localparam logic [DATA_W-1:0] CMD_PERIOD_RST = 32'd1000;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [DATA_W-1:0] wdata;
    } queue_ctrl_t;

    typedef struct packed {
        logic [PTR_W-1:0]  fill;
        logic [DATA_W-1:0] rdata;
    } queue_stat_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/step_dir_pulse_train_generator.sv */
// Channel  | handshake             | payload
// ---------+-----------------------+----------------------------------------------
// in       | in_valid / in_ready   | op, delta, reset_enable
// out      | out_valid / out_ready | accepted, step_pulse, direction_level,
//          |                       | driver_enable_level, timer_running, queue_count
// cfg      | cfg_write             | cfg_index, cfg_data
//
// Push, reset and microsecond-tick beats pass from S_IDLE to S_FIN and then to the
// output register; a command beat that pops passes through S_READ as well. A beat
// that loads a new command also waits in S_DIV on the bit-serial period divider.
// One beat is in work at a time; in_ready is high only while the sequencer idles.
// The result sits in an output register; the next beat may enter while it waits,
// and its own result is held back until the earlier one is taken.
// Reset clears all control state; queue contents stay undefined until pushed.
// Depends on sdpg_pkg, sdpg_queue, sdpg_divider and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module step_dir_pulse_train_generator
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [sdpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdpg_pkg::DATA_W-1:0]       cfg_data,
    // input beats
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic signed [sdpg_pkg::DATA_W-1:0] delta,
    input  logic                              reset_enable,
    // result beats
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic                              step_pulse,
    output logic                              direction_level,
    output logic                              driver_enable_level,
    output logic                              timer_running,
    output logic [sdpg_pkg::COUNT_W-1:0]      queue_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FIN
    } state_t;

    localparam logic [sdpg_pkg::PTR_W-1:0] FULL_FILL =
        sdpg_pkg::PTR_W'(sdpg_pkg::QUEUE_DEPTH - 1);
    localparam logic [sdpg_pkg::DATA_W-1:0] ONE = sdpg_pkg::DATA_W'(1);

    state_t                      state_reg;
    logic [sdpg_pkg::DATA_W-1:0] cmd_period_reg;
    logic                        dir_pol_reg;
    logic                        en_pol_reg;
    logic                        block_en_reg;
    logic                        timer_on_reg;
    logic [sdpg_pkg::DATA_W-1:0] steps_left_reg;
    logic [sdpg_pkg::DATA_W-1:0] pulse_period_reg;
    logic [sdpg_pkg::DATA_W-1:0] tick_cnt_reg;
    logic                        dir_bit_reg;
    logic [sdpg_pkg::DATA_W-1:0] pend_delta_reg;
    logic                        pend_valid_reg;
    logic                        acc_reg;
    logic                        pulse_reg;
    logic                        out_valid_reg;
    logic                        accepted_reg;
    logic                        step_pulse_reg;
    logic                        direction_level_reg;
    logic                        driver_enable_level_reg;
    logic                        timer_running_reg;
    logic [sdpg_pkg::COUNT_W-1:0] queue_count_reg;

    sdpg_pkg::queue_ctrl_t       q_ctrl;
    sdpg_pkg::queue_stat_t       q_stat;
    sdpg_pkg::div_req_t          div_req;
    sdpg_pkg::div_rsp_t          div_rsp;

    logic                        do_push;
    logic                        do_pop;
    logic                        do_clear;
    logic                        load_go;
    logic [sdpg_pkg::DATA_W-1:0] load_val;
    logic                        load_neg;
    logic [sdpg_pkg::DATA_W-1:0] load_mag;
    logic                        pulse_now;
    logic                        tick_upd;
    logic                        timer_off;
    logic                        pend_set;
    logic [sdpg_pkg::DATA_W-1:0] tick_inc;
    logic [sdpg_pkg::DATA_W-1:0] per_eff;
    logic                        tick_hit;
    logic                        steps_zero;
    logic                        out_free;

    sdpg_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    sdpg_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || out_ready;
    assign steps_zero = (steps_left_reg == '0);

    // Microsecond timer compare, zero period acts as one
    assign tick_inc = tick_cnt_reg + ONE;
    assign per_eff  = (pulse_period_reg == '0) ? ONE : pulse_period_reg;
    assign tick_hit = (tick_inc >= per_eff);

    // Beat decode: what this cycle does to the queue, timer and command slot
    always_comb
    begin
        do_push   = 1'b0;
        do_pop    = 1'b0;
        do_clear  = 1'b0;
        load_go   = 1'b0;
        load_val  = pend_delta_reg;
        pulse_now = 1'b0;
        tick_upd  = 1'b0;
        timer_off = 1'b0;
        pend_set  = 1'b0;
        if (state_reg == S_IDLE && in_valid)
        begin
            unique case (op)
                sdpg_pkg::OP_PUSH:
                    do_push = (q_stat.fill != FULL_FILL);
                sdpg_pkg::OP_CMD:
                begin
                    if (block_en_reg)
                    begin
                        if (pend_valid_reg)
                            load_go = steps_zero;
                        else if (q_stat.fill != '0)
                            do_pop = 1'b1;
                        else
                            timer_off = steps_zero;
                    end
                end
                sdpg_pkg::OP_TICK:
                begin
                    if (timer_on_reg)
                    begin
                        tick_upd = 1'b1;
                        if (tick_hit && !steps_zero)
                        begin
                            pulse_now = 1'b1;
                            load_go   = (steps_left_reg == ONE) && pend_valid_reg;
                        end
                    end
                end
                sdpg_pkg::OP_RESET:
                    do_clear = 1'b1;
            endcase
        end
        else if (state_reg == S_READ && q_stat.rdata != '0)
        begin
            // Popped a nonzero delta: park it or load it now
            if (!steps_zero)
                pend_set = 1'b1;
            else
            begin
                load_go  = 1'b1;
                load_val = q_stat.rdata;
            end
        end
    end

    // Step count and direction of the command being loaded
    assign load_neg = load_val[sdpg_pkg::DATA_W-1];
    assign load_mag = load_neg ? ('0 - load_val) : load_val;

    assign q_ctrl.push  = do_push;
    assign q_ctrl.pop   = do_pop;
    assign q_ctrl.clear = do_clear;
    assign q_ctrl.wdata = $unsigned(delta);

    assign div_req.start    = load_go;
    assign div_req.dividend = cmd_period_reg;
    assign div_req.divisor  = load_mag;

    // Sequencer, generator state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= S_IDLE;
            cmd_period_reg          <= sdpg_pkg::CMD_PERIOD_RST;
            dir_pol_reg             <= 1'b0;
            en_pol_reg              <= 1'b0;
            block_en_reg            <= 1'b0;
            timer_on_reg            <= 1'b0;
            steps_left_reg          <= '0;
            pulse_period_reg        <= '0;
            tick_cnt_reg            <= '0;
            dir_bit_reg             <= 1'b0;
            pend_delta_reg          <= '0;
            pend_valid_reg          <= 1'b0;
            acc_reg                 <= 1'b0;
            pulse_reg               <= 1'b0;
            out_valid_reg           <= 1'b0;
            accepted_reg            <= 1'b0;
            step_pulse_reg          <= 1'b0;
            direction_level_reg     <= 1'b0;
            driver_enable_level_reg <= 1'b0;
            timer_running_reg       <= 1'b0;
            queue_count_reg         <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    sdpg_pkg::CFG_PERIOD:  cmd_period_reg <= cfg_data;
                    sdpg_pkg::CFG_DIR_POL: dir_pol_reg    <= cfg_data[0];
                    sdpg_pkg::CFG_EN_POL:  en_pol_reg     <= cfg_data[0];
                    default:               ;
                endcase
            end

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            // sequencing
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        acc_reg   <= do_push;
                        pulse_reg <= pulse_now;
                        if (do_pop)
                            state_reg <= S_READ;
                        else if (load_go)
                            state_reg <= S_DIV;
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_READ:
                    state_reg <= load_go ? S_DIV : S_FIN;
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        pulse_period_reg <= (div_rsp.quotient == '0) ? ONE
                                                                     : div_rsp.quotient;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg           <= 1'b1;
                        accepted_reg            <= acc_reg;
                        step_pulse_reg          <= pulse_reg;
                        direction_level_reg     <= dir_bit_reg;
                        driver_enable_level_reg <= timer_on_reg ^ en_pol_reg;
                        timer_running_reg       <= timer_on_reg;
                        queue_count_reg         <= sdpg_pkg::COUNT_W'(q_stat.fill);
                        state_reg               <= S_IDLE;
                    end
                end
            endcase

            // timer and step count
            if (tick_upd)
                tick_cnt_reg <= tick_hit ? '0 : tick_inc;
            if (pulse_now)
                steps_left_reg <= steps_left_reg - ONE;
            if (timer_off)
                timer_on_reg <= 1'b0;
            if (pend_set)
            begin
                pend_delta_reg <= q_stat.rdata;
                pend_valid_reg <= 1'b1;
            end

            // command load, period follows from the divider
            if (load_go)
            begin
                steps_left_reg <= load_mag;
                dir_bit_reg    <= load_neg ^ dir_pol_reg;
                tick_cnt_reg   <= '0;
                timer_on_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end

            // reset op
            if (do_clear)
            begin
                pulse_period_reg <= '0;
                steps_left_reg   <= '0;
                dir_bit_reg      <= 1'b0;
                tick_cnt_reg     <= '0;
                timer_on_reg     <= reset_enable;
                block_en_reg     <= reset_enable;
                pend_delta_reg   <= '0;
                pend_valid_reg   <= 1'b0;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign accepted            = accepted_reg;
    assign step_pulse          = step_pulse_reg;
    assign direction_level     = direction_level_reg;
    assign driver_enable_level = driver_enable_level_reg;
    assign timer_running       = timer_running_reg;
    assign queue_count         = queue_count_reg;

    `SDPG_ASSERT_IMP(a_pend_has_steps, clk, rst_n, pend_valid_reg, steps_left_reg != '0)
    `SDPG_ASSERT_IMP(a_div_free, clk, rst_n, div_req.start, !div_rsp.busy)

endmodule

`default_nettype wire

/* hw/rtl/sdpg_queue.sv */
// Ring command queue for the step/dir generator: memory, pointers, fill count.
// Depends on sdpg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sdpg_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdpg_pkg::queue_ctrl_t ctrl,
    output sdpg_pkg::queue_stat_t stat
);

    localparam logic [sdpg_pkg::PTR_W-1:0] LAST_PTR =
        sdpg_pkg::PTR_W'(sdpg_pkg::QUEUE_DEPTH - 1);
    localparam logic [sdpg_pkg::PTR_W:0] DEPTH_EXT =
        (sdpg_pkg::PTR_W + 1)'(sdpg_pkg::QUEUE_DEPTH);

    logic [sdpg_pkg::DATA_W-1:0] mem [sdpg_pkg::QUEUE_DEPTH];
    logic [sdpg_pkg::DATA_W-1:0] rdata_reg;
    logic [sdpg_pkg::PTR_W-1:0]  wr_ptr_reg;
    logic [sdpg_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [sdpg_pkg::PTR_W-1:0]  fill;
    logic [sdpg_pkg::PTR_W:0]    fill_wrap;

    // Fill count from the two pointers
    assign fill_wrap = DEPTH_EXT - {1'b0, rd_ptr_reg} + {1'b0, wr_ptr_reg};
    assign fill      = (wr_ptr_reg >= rd_ptr_reg) ? (wr_ptr_reg - rd_ptr_reg)
                                                  : fill_wrap[sdpg_pkg::PTR_W-1:0];

    assign stat.fill  = fill;
    assign stat.rdata = rdata_reg;

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (ctrl.push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (ctrl.pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[wr_ptr_reg] <= ctrl.wdata;
        if (ctrl.pop)
            rdata_reg <= mem[rd_ptr_reg];
    end

    `SDPG_ASSERT_IMP(a_no_overflow, clk, rst_n, ctrl.push, fill != LAST_PTR)
    `SDPG_ASSERT_IMP(a_no_underflow, clk, rst_n, ctrl.pop, fill != '0)

endmodule

`default_nettype wire

/* hw/rtl/sdpg_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by all command loads.
// Depends on sdpg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sdpg_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  sdpg_pkg::div_req_t req,
    output sdpg_pkg::div_rsp_t rsp
);

    localparam logic [sdpg_pkg::DIV_CNT_W-1:0] LAST_STEP =
        sdpg_pkg::DIV_CNT_W'(sdpg_pkg::DATA_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [sdpg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [sdpg_pkg::DATA_W-1:0]   rem_reg;
    logic [sdpg_pkg::DATA_W-1:0]   quo_reg;
    logic [sdpg_pkg::DATA_W-1:0]   dvs_reg;
    logic [sdpg_pkg::DATA_W:0]     trial;
    logic [sdpg_pkg::DATA_W:0]     diff;
    logic                          fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[sdpg_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // Control: step count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[sdpg_pkg::DATA_W-1:0] : trial[sdpg_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[sdpg_pkg::DATA_W-2:0], fits};
        end
    end

    `SDPG_ASSERT_NXT(a_start_runs, clk, rst_n, req.start, busy_reg)
    `SDPG_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

`default_nettype wire

/* tb/tb_step_dir_pulse_train_generator.sv */
// Self-checking testbench for step_dir_pulse_train_generator: directed and random beats,
// results checked against a behavioral predictor of the queue, timer and direction logic.
// Depends on sdpg_pkg and the step_dir_pulse_train_generator RTL.
`timescale 1ns / 1ps

module tb_step_dir_pulse_train_generator;

    localparam int QUIET_LIMIT  = 1000;  // cycles with no beat on either channel
    localparam int DRAIN_CYCLES = 40;    // covers a loading beat, which waits on the divider
    localparam int IDLE_PCT     = 14;
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic                         accepted;
        logic                         step_pulse;
        logic                         direction_level;
        logic                         driver_enable_level;
        logic                         timer_running;
        logic [sdpg_pkg::COUNT_W-1:0] queue_count;
    } pin_status_t;

    // DUT ports
    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_write = 1'b0;
    logic [sdpg_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [sdpg_pkg::DATA_W-1:0]        cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [1:0]                         op = sdpg_pkg::OP_PUSH;
    logic signed [sdpg_pkg::DATA_W-1:0] delta = '0;
    logic                               reset_enable = 1'b0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic                               accepted;
    logic                               step_pulse;
    logic                               direction_level;
    logic                               driver_enable_level;
    logic                               timer_running;
    logic [sdpg_pkg::COUNT_W-1:0]       queue_count;

    // Predictor copy of the registers
    logic [sdpg_pkg::DATA_W-1:0] cmd_period;
    logic                        dir_pol;
    logic                        en_pol;

    // Predictor copy of the block state
    logic [sdpg_pkg::DATA_W-1:0] move_fifo [sdpg_pkg::QUEUE_DEPTH];
    int unsigned                 wr_ptr;
    int unsigned                 rd_ptr;
    logic                        block_on;
    logic                        timer_on;
    logic [sdpg_pkg::DATA_W-1:0] steps_left;
    logic [sdpg_pkg::DATA_W-1:0] pulse_period;
    logic [sdpg_pkg::DATA_W-1:0] tick_count;
    logic                        dir_bit;
    logic [sdpg_pkg::DATA_W-1:0] held_delta;
    logic                        held_valid;

    pin_status_t predicted_status [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          steady_flow = 1'b0;

    step_dir_pulse_train_generator DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .op                  (op),
        .delta               (delta),
        .reset_enable        (reset_enable),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .accepted            (accepted),
        .step_pulse          (step_pulse),
        .direction_level     (direction_level),
        .driver_enable_level (driver_enable_level),
        .timer_running       (timer_running),
        .queue_count         (queue_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned ptr_next(input int unsigned p);
        return (p == sdpg_pkg::QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic int unsigned fifo_fill();
        if (wr_ptr >= rd_ptr)
            return wr_ptr - rd_ptr;
        return sdpg_pkg::QUEUE_DEPTH - rd_ptr + wr_ptr;
    endfunction

    // Load a nonzero move: magnitude, direction and per-step period
    function automatic void load_move(input logic [sdpg_pkg::DATA_W-1:0] d);
        logic [sdpg_pkg::DATA_W-1:0] mag;
        logic [sdpg_pkg::DATA_W-1:0] quot;
        mag          = d[sdpg_pkg::DATA_W-1] ? (~d + 1'b1) : d;
        quot         = cmd_period / mag;
        steps_left   = mag;
        dir_bit      = d[sdpg_pkg::DATA_W-1] ^ dir_pol;
        pulse_period = (quot == '0) ? 1 : quot;
        tick_count   = '0;
        timer_on     = 1'b1;
    endfunction

    function automatic void clear_motion();
        wr_ptr       = 0;
        rd_ptr       = 0;
        steps_left   = '0;
        pulse_period = '0;
        tick_count   = '0;
        dir_bit      = 1'b0;
        held_delta   = '0;
        held_valid   = 1'b0;
    endfunction

    function automatic pin_status_t predict_status(input logic [1:0] code,
                                                   input logic [sdpg_pkg::DATA_W-1:0] d,
                                                   input logic en);
        pin_status_t                 s;
        logic [sdpg_pkg::DATA_W-1:0] word;
        logic [sdpg_pkg::DATA_W-1:0] period;
        s = '0;
        case (code)
            sdpg_pkg::OP_PUSH:
            begin
                if (fifo_fill() < sdpg_pkg::QUEUE_DEPTH - 1)
                begin
                    move_fifo[wr_ptr] = d;
                    wr_ptr            = ptr_next(wr_ptr);
                    s.accepted        = 1'b1;
                end
            end
            sdpg_pkg::OP_CMD:
            begin
                if (block_on)
                begin
                    if (held_valid)
                    begin
                        if (steps_left == '0)
                        begin
                            held_valid = 1'b0;
                            load_move(held_delta);
                        end
                    end
                    else if (fifo_fill() > 0)
                    begin
                        word   = move_fifo[rd_ptr];
                        rd_ptr = ptr_next(rd_ptr);
                        // zero moves are dropped; a move popped while stepping waits
                        if (word != '0)
                        begin
                            if (steps_left != '0)
                            begin
                                held_delta = word;
                                held_valid = 1'b1;
                            end
                            else
                                load_move(word);
                        end
                    end
                    else if (steps_left == '0)
                        timer_on = 1'b0;
                end
            end
            sdpg_pkg::OP_TICK:
            begin
                if (timer_on)
                begin
                    period     = (pulse_period == '0) ? 1 : pulse_period;
                    tick_count = tick_count + 1;
                    if (tick_count >= period)
                    begin
                        tick_count = '0;
                        if (steps_left != '0)
                        begin
                            s.step_pulse = 1'b1;
                            steps_left   = steps_left - 1;
                            if (steps_left == '0 && held_valid)
                            begin
                                held_valid = 1'b0;
                                load_move(held_delta);
                            end
                        end
                    end
                end
            end
            default:
            begin
                clear_motion();
                timer_on = en;
                block_on = en;
            end
        endcase
        s.direction_level     = dir_bit;
        s.driver_enable_level = timer_on ^ en_pol;
        s.timer_running       = timer_on;
        s.queue_count         = sdpg_pkg::COUNT_W'(fifo_fill());
        return s;
    endfunction

    // ---------------------------------------------------------------- monitor

    task automatic check_field(input string field, input logic [sdpg_pkg::DATA_W-1:0] want,
                               input logic [sdpg_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endtask

    // Predict on each input beat, check each result beat, drive out_ready
    always @(posedge clk)
    begin : monitor
        pin_status_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predicted_status.push_back(predict_status(op, delta, reset_enable));
            if (out_valid && out_ready)
            begin
                if (predicted_status.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with no expectation waiting", $time);
                end
                else
                begin
                    want = predicted_status.pop_front();
                    check_field("accepted", sdpg_pkg::DATA_W'(want.accepted),
                                sdpg_pkg::DATA_W'(accepted));
                    check_field("step_pulse", sdpg_pkg::DATA_W'(want.step_pulse),
                                sdpg_pkg::DATA_W'(step_pulse));
                    check_field("direction_level", sdpg_pkg::DATA_W'(want.direction_level),
                                sdpg_pkg::DATA_W'(direction_level));
                    check_field("driver_enable_level",
                                sdpg_pkg::DATA_W'(want.driver_enable_level),
                                sdpg_pkg::DATA_W'(driver_enable_level));
                    check_field("timer_running", sdpg_pkg::DATA_W'(want.timer_running),
                                sdpg_pkg::DATA_W'(timer_running));
                    check_field("queue_count", sdpg_pkg::DATA_W'(want.queue_count),
                                sdpg_pkg::DATA_W'(queue_count));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: stop a hung run
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_beat(input logic [1:0] code, input logic [sdpg_pkg::DATA_W-1:0] d,
                             input logic en);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= code;
        delta        <= d;
        reset_enable <= en;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Wait until every result is back and the block has gone quiet
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predicted_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sdpg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sdpg_pkg::DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            sdpg_pkg::CFG_PERIOD:  cmd_period = value;
            sdpg_pkg::CFG_DIR_POL: dir_pol    = value[0];
            sdpg_pkg::CFG_EN_POL:  en_pol     = value[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [sdpg_pkg::DATA_W-1:0] period, input logic dpol,
                            input logic epol);
        settle_block();
        write_reg(sdpg_pkg::CFG_PERIOD, period);
        write_reg(sdpg_pkg::CFG_DIR_POL, {31'd0, dpol});
        write_reg(sdpg_pkg::CFG_EN_POL, {31'd0, epol});
    endtask

    // Mostly short moves so that they finish; some zero, extreme and raw values
    function automatic logic [sdpg_pkg::DATA_W-1:0] pick_delta();
        int unsigned                 sel;
        logic [sdpg_pkg::DATA_W-1:0] mag;
        sel = $urandom_range(0, 99);
        mag = $urandom_range(1, 6);
        if (sel < 10)
            return '0;
        if (sel < 20)
            return $urandom;
        if (sel < 28)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0001;
                2:       return 32'h8000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
    endfunction

    task automatic run_random(input int count);
        int unsigned sel;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                send_beat(sdpg_pkg::OP_PUSH, pick_delta(), 1'($urandom));
            else if (sel < 50)
                send_beat(sdpg_pkg::OP_CMD, $urandom, 1'($urandom));
            else if (sel < 97)
                send_beat(sdpg_pkg::OP_TICK, $urandom, 1'($urandom));
            else
                send_beat(sdpg_pkg::OP_RESET, $urandom, $urandom_range(0, 99) < 85);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Reset register values, disabled block, corner moves and the held slot
    task automatic test_power_on();
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b0);            // disabled: no pop
        send_beat(sdpg_pkg::OP_TICK, 32'd0, 1'b1);           // timer off
        send_beat(sdpg_pkg::OP_PUSH, 32'd5, 1'b0);           // stored while disabled
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b1);
        send_beat(sdpg_pkg::OP_RESET, 32'hFFFF_FFFF, 1'b0);
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b1);
        send_beat(sdpg_pkg::OP_TICK, 32'd0, 1'b0);           // zero period runs as one
        send_beat(sdpg_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b0);
        send_beat(sdpg_pkg::OP_PUSH, 32'd0, 1'b1);
        send_beat(sdpg_pkg::OP_PUSH, 32'h8000_0000, 1'b0);   // most negative move
        send_beat(sdpg_pkg::OP_PUSH, 32'h8000_0001, 1'b1);
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b0);            // loads, period floors to one
        send_beat(sdpg_pkg::OP_TICK, 32'd0, 1'b0);
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b0);            // zero move dropped
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b0);            // popped into the held slot
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b0);            // held, nothing pops
        send_beat(sdpg_pkg::OP_TICK, 32'd0, 1'b1);
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b1);
        send_beat(sdpg_pkg::OP_PUSH, 32'd3, 1'b0);
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b0);
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b0);            // empty queue, steps remain
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b0);
        send_beat(sdpg_pkg::OP_CMD, 32'd0, 1'b1);
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b1);
        run_random(60);
    endtask

    // Fill past capacity, then drain part of it
    task automatic test_queue_full();
        set_regs(32'd1, 1'b1, 1'b1);
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b1);
        repeat (sdpg_pkg::QUEUE_DEPTH + 2)
            send_beat(sdpg_pkg::OP_PUSH, pick_delta(), 1'($urandom));
        run_random(30);
    endtask

    task automatic test_fast_period();
        set_regs($urandom_range(2, 24), 1'b0, 1'b1);
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b1);
        run_random(130);
    endtask

    task automatic test_extreme_period();
        set_regs(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b1);
        run_random(80);
    endtask

    // Back-to-back beats on both channels
    task automatic test_no_idle_burst();
        set_regs($urandom_range(1, 12), 1'($urandom), 1'($urandom));
        steady_flow = 1'b1;
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b1);
        run_random(130);
        steady_flow = 1'b0;
    endtask

    task automatic test_mixed_settings();
        set_regs($urandom_range(3, 16), 1'b0, 1'b0);
        send_beat(sdpg_pkg::OP_RESET, 32'd0, 1'b1);
        run_random(120);
    endtask

    initial
    begin
        cmd_period = sdpg_pkg::CMD_PERIOD_RST;
        dir_pol    = 1'b0;
        en_pol     = 1'b0;
        block_on   = 1'b0;
        timer_on   = 1'b0;
        clear_motion();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_queue_full();
        test_fast_period();
        test_extreme_period();
        test_no_idle_burst();
        test_mixed_settings();
        settle_block();

        if (mismatches == 0 && predicted_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sdpg_pkg.sv
hw/rtl/sdpg_queue.sv
hw/rtl/sdpg_divider.sv
hw/rtl/step_dir_pulse_train_generator.sv
tb/tb_step_dir_pulse_train_generator.sv
